/* design/swrb_pkg.sv */
// Shared types and constants of the sliding window receive buffer.
// Used by swrb_mod and sliding_window_receive_buffer_core; no dependencies.
package swrb_pkg;

  localparam int SEQ_W = 16;
  localparam int FREE_W = 5;
  localparam int KIND_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_WINDOW_DEF = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [FREE_W-1:0] WIN_RST = 5'd16;
  localparam logic [SEQ_W-1:0] START_RST = 16'd3;
  localparam logic [SEQ_W-1:0] NO_POINTER = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ = 1'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA  = 2'd0,
    KIND_FIN   = 2'd1,
    KIND_PROBE = 2'd2,
    KIND_DRAIN = 2'd3
  } kind_e;

  typedef enum logic [KIND_W-1:0] {
    RES_DATA_ACK = 2'd0,
    RES_FIN_ACK  = 2'd1,
    RES_WIN_UPD  = 2'd2,
    RES_DELIVER  = 2'd3
  } res_kind_e;

endpackage

/* design/swrb_mod.sv */
// Bit-serial remainder of a sequence number by the window size in use.
// Depends on swrb_pkg for the sequence and count widths.
module swrb_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [swrb_pkg::SEQ_W-1:0]  dividend_i,
  input  logic [swrb_pkg::FREE_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [swrb_pkg::FREE_W-1:0] rem_o
);
  import swrb_pkg::*;

  localparam int CNT_W = $clog2(SEQ_W + 1);

  logic [SEQ_W-1:0]  dvd_q;
  logic [FREE_W-1:0] dvs_q;
  logic [FREE_W-1:0] rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [FREE_W:0]   shifted;
  logic [FREE_W:0]   reduced;

  always_comb begin
    shifted = {rem_q, dvd_q[SEQ_W-1]};
    if (shifted >= {1'b0, dvs_q}) begin
      reduced = shifted - {1'b0, dvs_q};
    end else begin
      reduced = shifted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(SEQ_W);
        dvd_q  <= dividend_i;
        dvs_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= reduced[FREE_W-1:0];
        dvd_q <= {dvd_q[SEQ_W-2:0], 1'b0};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* design/sliding_window_receive_buffer_core.sv */
// Selective-repeat receive window: slot store, window start advance and drain.
// Depends on swrb_pkg and swrb_mod.
// Data or FIN packet: swrb_mod gives the slot index, the item is stored, the window start advance
// passes the filled slots after it unless the free count runs out, and the ack is loaded from
// ST_EMIT. Next item once back in ST_IDLE. Probe with free space: the window update is loaded
// from ST_EMIT. Drain: each delivered item is read from the payload RAM, then loaded. A result
// held by out_ready_i stalls the block. Reset clears the valid bits at once; a configuration
// write clears them and recomputes the start slot index with swrb_mod.
module sliding_window_receive_buffer_core #(
  parameter int MAX_WINDOW = swrb_pkg::MAX_WINDOW_DEF,
  parameter int DATA_WIDTH = swrb_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [swrb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [swrb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [swrb_pkg::KIND_W-1:0]     kind_i,
  input  logic [swrb_pkg::SEQ_W-1:0]      seq_num_i,
  input  logic [DATA_WIDTH-1:0]           payload_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [swrb_pkg::KIND_W-1:0]     result_kind_o,
  output logic [swrb_pkg::SEQ_W-1:0]      ack_seq_o,
  output logic [swrb_pkg::FREE_W-1:0]     window_free_o,
  output logic                            accepted_o,
  output logic [DATA_WIDTH-1:0]           data_word_o,
  output logic                            last_o
);
  import swrb_pkg::*;

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_RST_USE = (WIN_RST == '0) ? 1 :
                               ((int'(WIN_RST) > MAX_WINDOW) ? MAX_WINDOW : int'(WIN_RST));
  localparam logic [IDX_W-1:0] WS_IDX_RST = IDX_W'(int'(START_RST) % WIN_RST_USE);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_INIT = 7'b0000010,
    ST_MOD  = 7'b0000100,
    ST_ADV  = 7'b0001000,
    ST_EMIT = 7'b0010000,
    ST_DRD  = 7'b0100000,
    ST_DOUT = 7'b1000000
  } state_e;

  function automatic logic [FREE_W-1:0] win_clamp(input logic [FREE_W-1:0] v);
    if (v == '0) return FREE_W'(1);
    if (int'(v) > MAX_WINDOW) return FREE_W'(MAX_WINDOW);
    return v;
  endfunction

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx,
                                               input logic [SEQ_W-1:0] nxt,
                                               input logic [FREE_W-1:0] w);
    logic [IDX_W:0] sum;
    sum = {1'b0, idx} + (IDX_W+1)'(1);
    if (nxt == '0 || sum == (IDX_W+1)'(w)) return '0;
    return sum[IDX_W-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [FREE_W-1:0] win_cfg_q, win_cfg_d;
  logic [SEQ_W-1:0]  start_cfg_q, start_cfg_d;
  logic [SEQ_W-1:0]  ws_q, ws_d;
  logic [IDX_W-1:0]  ws_idx_q, ws_idx_d;
  logic [FREE_W-1:0] free_q, free_d;
  logic [SEQ_W-1:0]  rs_q, rs_d;
  logic [IDX_W-1:0]  rs_idx_q, rs_idx_d;
  logic              rs_set_q, rs_set_d;
  logic              valid_q [MAX_WINDOW];
  logic              valid_d [MAX_WINDOW];
  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic [DATA_WIDTH-1:0] pay_q, pay_d;
  res_kind_e         pend_q, pend_d;
  logic              acc_q, acc_d;
  logic [FREE_W-1:0] n_q, n_d;
  logic [SEQ_W-1:0]  dseq_q, dseq_d;
  logic              last_q, last_d;

  logic [DATA_WIDTH-1:0] slot_mem_q [MAX_WINDOW];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic                  mem_we;
  logic                  mem_re;

  logic              out_valid_q;
  res_kind_e         out_kind_q;
  logic [SEQ_W-1:0]  out_seq_q;
  logic [FREE_W-1:0] out_free_q;
  logic              out_acc_q;
  logic [DATA_WIDTH-1:0] out_data_q;
  logic              out_last_q;
  logic              out_load;
  res_kind_e         ld_kind;
  logic [SEQ_W-1:0]  ld_seq;
  logic              ld_acc;
  logic [DATA_WIDTH-1:0] ld_data;
  logic              ld_last;
  logic              out_room;

  logic              mod_start;
  logic [SEQ_W-1:0]  mod_dvd;
  logic [FREE_W-1:0] mod_dvs;
  logic              mod_done;
  logic [FREE_W-1:0] mod_rem;
  logic [IDX_W-1:0]  rem_idx;

  logic [FREE_W-1:0] w_use;
  logic [FREE_W-1:0] win_new;
  logic [SEQ_W-1:0]  start_new;
  logic [FREE_W-1:0] free_dec;
  logic [SEQ_W-1:0]  ws_inc;
  logic [SEQ_W-1:0]  rs_inc;
  logic [IDX_W-1:0]  rs_idx_nxt;

  swrb_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dvd),
    .divisor_i  (mod_dvs),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign rem_idx    = IDX_W'(mod_rem);
  assign w_use      = win_clamp(win_cfg_q);
  assign out_room   = !out_valid_q || out_ready_i;
  assign free_dec   = (free_q == '0) ? '0 : free_q - FREE_W'(1);
  assign ws_inc     = ws_q + SEQ_W'(1);
  assign rs_inc     = rs_q + SEQ_W'(1);
  assign rs_idx_nxt = idx_inc(rs_idx_q, rs_inc, w_use);
  assign win_new    = (cfg_idx_i == CFG_WINDOW_SIZE) ? cfg_data_i[FREE_W-1:0] : win_cfg_q;
  assign start_new  = (cfg_idx_i == CFG_START_SEQ) ? cfg_data_i[SEQ_W-1:0] : start_cfg_q;

  always_comb begin
    state_d     = state_q;
    win_cfg_d   = win_cfg_q;
    start_cfg_d = start_cfg_q;
    ws_d        = ws_q;
    ws_idx_d    = ws_idx_q;
    free_d      = free_q;
    rs_d        = rs_q;
    rs_idx_d    = rs_idx_q;
    rs_set_d    = rs_set_q;
    valid_d     = valid_q;
    seq_d       = seq_q;
    pay_d       = pay_q;
    pend_d      = pend_q;
    acc_d       = acc_q;
    n_d         = n_q;
    dseq_d      = dseq_q;
    last_d      = last_q;
    mod_start   = 1'b0;
    mod_dvd     = seq_num_i;
    mod_dvs     = w_use;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    out_load    = 1'b0;
    ld_kind     = pend_q;
    ld_seq      = ws_q;
    ld_acc      = acc_q;
    ld_data     = '0;
    ld_last     = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          seq_d = seq_num_i;
          pay_d = payload_word_i;
          if (kind_i == KIND_DRAIN) begin
            if (free_q != w_use && rs_set_q && valid_q[rs_idx_q]) begin
              n_d     = '0;
              state_d = ST_DRD;
            end
          end else if (kind_i == KIND_PROBE && free_q != '0) begin
            pend_d  = RES_WIN_UPD;
            acc_d   = 1'b0;
            state_d = ST_EMIT;
          end else begin
            pend_d    = (kind_i == KIND_FIN) ? RES_FIN_ACK : RES_DATA_ACK;
            mod_start = 1'b1;
            state_d   = ST_MOD;
          end
        end
      end
      ST_INIT: begin
        if (mod_done) begin
          ws_idx_d = rem_idx;
          state_d  = ST_IDLE;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          if (valid_q[rem_idx]) begin
            acc_d   = 1'b0;
            state_d = ST_EMIT;
          end else begin
            acc_d            = 1'b1;
            mem_we           = 1'b1;
            valid_d[rem_idx] = 1'b1;
            if (!rs_set_q) begin
              rs_d     = seq_q;
              rs_idx_d = rem_idx;
              rs_set_d = 1'b1;
            end
            if (ws_q == seq_q) begin
              free_d   = free_dec;
              ws_d     = ws_inc;
              ws_idx_d = idx_inc(rem_idx, ws_inc, w_use);
              n_d      = '0;
              state_d  = (free_dec == '0) ? ST_EMIT : ST_ADV;
            end else begin
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_ADV: begin
        if (n_q == w_use || !valid_q[ws_idx_q] || ws_q == rs_q) begin
          state_d = ST_EMIT;
        end else begin
          ws_d     = ws_inc;
          ws_idx_d = idx_inc(ws_idx_q, ws_inc, w_use);
          free_d   = free_dec;
          n_d      = n_q + FREE_W'(1);
          if (free_dec == '0) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_room) begin
          out_load = 1'b1;
          if (pend_q == RES_WIN_UPD) begin
            ld_seq = rs_set_q ? rs_q : NO_POINTER;
          end
          state_d = ST_IDLE;
        end
      end
      ST_DRD: begin
        mem_re            = 1'b1;
        dseq_d            = rs_q;
        valid_d[rs_idx_q] = 1'b0;
        if (free_q < w_use) begin
          free_d = free_q + FREE_W'(1);
        end
        rs_d     = rs_inc;
        rs_idx_d = rs_idx_nxt;
        n_d      = n_q + FREE_W'(1);
        last_d   = (({1'b0, n_q} + (FREE_W+1)'(1)) == {1'b0, w_use}) || !valid_q[rs_idx_nxt];
        state_d  = ST_DOUT;
      end
      ST_DOUT: begin
        if (out_room) begin
          out_load = 1'b1;
          ld_kind  = RES_DELIVER;
          ld_seq   = dseq_q;
          ld_acc   = 1'b0;
          ld_data  = rdata_q;
          ld_last  = last_q;
          state_d  = last_q ? ST_IDLE : ST_DRD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      win_cfg_d   = win_new;
      start_cfg_d = start_new;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        valid_d[i] = 1'b0;
      end
      ws_d      = start_new;
      free_d    = win_clamp(win_new);
      rs_d      = '0;
      rs_idx_d  = '0;
      rs_set_d  = 1'b0;
      mod_start = 1'b1;
      mod_dvd   = start_new;
      mod_dvs   = win_clamp(win_new);
      state_d   = ST_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_cfg_q   <= WIN_RST;
      start_cfg_q <= START_RST;
      ws_q        <= START_RST;
      ws_idx_q    <= WS_IDX_RST;
      free_q      <= FREE_W'(WIN_RST_USE);
      rs_q        <= '0;
      rs_idx_q    <= '0;
      rs_set_q    <= 1'b0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        valid_q[i] <= 1'b0;
      end
      n_q         <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_cfg_q   <= win_cfg_d;
      start_cfg_q <= start_cfg_d;
      ws_q        <= ws_d;
      ws_idx_q    <= ws_idx_d;
      free_q      <= free_d;
      rs_q        <= rs_d;
      rs_idx_q    <= rs_idx_d;
      rs_set_q    <= rs_set_d;
      valid_q     <= valid_d;
      n_q         <= n_d;
      last_q      <= last_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q  <= seq_d;
    pay_q  <= pay_d;
    pend_q <= pend_d;
    acc_q  <= acc_d;
    dseq_q <= dseq_d;
    if (out_load) begin
      out_kind_q <= ld_kind;
      out_seq_q  <= ld_seq;
      out_free_q <= free_q;
      out_acc_q  <= ld_acc;
      out_data_q <= ld_data;
      out_last_q <= ld_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[rem_idx] <= pay_q;
    end
    if (mem_re) begin
      rdata_q <= slot_mem_q[rs_idx_q];
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign ack_seq_o     = out_seq_q;
  assign window_free_o = out_free_q;
  assign accepted_o    = out_acc_q;
  assign data_word_o   = out_data_q;
  assign last_o        = out_last_q;

endmodule
